>>> sv/tpim_pkg.sv
// Package for the triangular pair/index map: shared word types, field widths,
// operation codes and pipeline depth constants.
// No dependencies.
package tpim_pkg;

  localparam int unsigned RowW = 16;
  localparam int unsigned IdxW = 31;
  localparam int unsigned ProdW = 32;
  localparam int unsigned RadW = 32;
  localparam int unsigned RootW = 16;
  localparam int unsigned RemW = 20;

  localparam int unsigned SqrtSteps = RadW / 2;
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned SqrtStages = SqrtSteps / StepsPerStage;
  localparam int unsigned FrontStages = 2;
  localparam int unsigned BackStages = 3;
  localparam int unsigned Latency = FrontStages + SqrtStages + BackStages;

  localparam logic OpPairToIndex = 1'b0;
  localparam logic OpIndexToPair = 1'b1;

  typedef struct packed {
    logic            op;
    logic [RowW-1:0] row_in;
    logic [RowW-1:0] col_in;
    logic [IdxW-1:0] index_in;
  } tpim_req_t;

  typedef struct packed {
    logic [RowW-1:0] row_out;
    logic [RowW-1:0] col_out;
    logic [IdxW-1:0] index_out;
    logic            bad_operand;
  } tpim_res_t;

  typedef struct packed {
    logic            op;
    logic            bad;
    logic [RowW-1:0] row;
    logic [RowW-1:0] col;
    logic [IdxW-1:0] index;
    logic [RowW-1:0] dim;
    logic [IdxW-1:0] total;
  } tpim_ctx_t;

endpackage

>>> sv/triangular_pair_index_map_top.sv
// Top level of the strict upper-triangle pair/index map: dimension register,
// front stages, square-root pipeline and back stages.
// Depends on tpim_pkg, tpim_front, tpim_isqrt and tpim_back.
//
// Usage: drive req_i and raise start for one cycle per word; a word is taken
// at every rising edge where start is high and busy is low. busy stays low, so
// a new word may enter on every cycle. op selects pair-to-index or
// index-to-pair.
// Each word yields one result word on res_o, marked by done_o for exactly one
// cycle, after the word passes two front stages, four square-root stages of
// four digits each and three back stages.
// Throughput is one word per cycle; the pipeline has no stall path because
// the receiver takes every result in the cycle it appears.
// The dimension register is written through cfg_we_i/cfg_wdata_i, masked to
// DIM_BITS bits; write it only while the pipeline is empty (not enforced).
// Reset clears the dimension to 2 and empties the pipeline; no clearing pass.
module triangular_pair_index_map_top #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  tpim_pkg::tpim_req_t           req_i,
  output logic                          done_o,
  output tpim_pkg::tpim_res_t           res_o,
  input  logic                          cfg_we_i,
  input  logic [tpim_pkg::RowW-1:0]     cfg_wdata_i
);

  localparam int unsigned DimW = (DIM_BITS < tpim_pkg::RowW) ? DIM_BITS : tpim_pkg::RowW;

  logic [DimW-1:0]               dim_q;
  logic [tpim_pkg::RowW-1:0]     dim_ext;
  logic                          accept;

  logic                          f_vld;
  tpim_pkg::tpim_ctx_t           f_ctx;
  logic [tpim_pkg::RadW-1:0]     f_rad;
  logic                          s_vld;
  tpim_pkg::tpim_ctx_t           s_ctx;
  logic [tpim_pkg::RootW-1:0]    s_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DimW'(2);
    end else if (cfg_we_i) begin
      dim_q <= cfg_wdata_i[DimW-1:0];
    end
  end

  assign dim_ext = tpim_pkg::RowW'(dim_q);
  assign busy    = 1'b0;
  assign accept  = start && !busy;

  tpim_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .dim_i   (dim_ext),
    .valid_o (f_vld),
    .ctx_o   (f_ctx),
    .rad_o   (f_rad)
  );

  tpim_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .ctx_i   (f_ctx),
    .rad_i   (f_rad),
    .valid_o (s_vld),
    .ctx_o   (s_ctx),
    .root_o  (s_root)
  );

  tpim_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_vld),
    .ctx_i   (s_ctx),
    .root_i  (s_root),
    .valid_o (done_o),
    .res_o   (res_o)
  );

`ifndef NO_ASSERTIONS
  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, tpim_pkg::Latency))
    else $error("result word without an accepted word");

  a_pair_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(accept && req_i.op == tpim_pkg::OpPairToIndex, tpim_pkg::Latency)
    |-> res_o.row_out == $past(req_i.row_in, tpim_pkg::Latency)
        && res_o.col_out == $past(req_i.col_in, tpim_pkg::Latency))
    else $error("pair not echoed");

  a_index_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(accept && req_i.op == tpim_pkg::OpIndexToPair, tpim_pkg::Latency)
    |-> res_o.index_out == $past(req_i.index_in, tpim_pkg::Latency))
    else $error("index not echoed");

  a_good_pair_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.bad_operand |-> res_o.row_out < res_o.col_out)
    else $error("legal result with row not below column");
`endif

endmodule

>>> sv/tpim_front.sv
// Front stages: triangle numbers, pair-to-index result, range checks and the
// radicand for the square root. Depends on tpim_pkg.
module tpim_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tpim_pkg::tpim_req_t           req_i,
  input  logic [tpim_pkg::RowW-1:0]     dim_i,
  output logic                          valid_o,
  output tpim_pkg::tpim_ctx_t           ctx_o,
  output logic [tpim_pkg::RadW-1:0]     rad_o
);

  logic                          vld1_q;
  tpim_pkg::tpim_req_t           req1_q;
  logic [tpim_pkg::RowW-1:0]     dim1_q;
  logic [tpim_pkg::IdxW-1:0]     tot1_q;
  logic [tpim_pkg::IdxW-1:0]     trir1_q;

  logic [tpim_pkg::RowW-1:0]     dsub;
  logic [tpim_pkg::ProdW-1:0]    prod_n;
  logic [tpim_pkg::ProdW-1:0]    prod_r;

  logic                          vld2_q;
  tpim_pkg::tpim_ctx_t           ctx2_d;
  tpim_pkg::tpim_ctx_t           ctx2_q;
  logic [tpim_pkg::RadW-1:0]     rad2_d;
  logic [tpim_pkg::RadW-1:0]     rad2_q;

  logic                          bad_pair;
  logic                          bad_idx;
  logic [tpim_pkg::IdxW-1:0]     idx_calc;
  logic [tpim_pkg::IdxW-1:0]     q_back;

  always_comb begin
    dsub   = dim_i - req_i.row_in;
    prod_n = tpim_pkg::ProdW'(dim_i) * tpim_pkg::ProdW'(dim_i - 16'd1);
    prod_r = tpim_pkg::ProdW'(dsub) * tpim_pkg::ProdW'(dsub - 16'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req1_q  <= req_i;
    dim1_q  <= dim_i;
    tot1_q  <= prod_n[tpim_pkg::ProdW-1:1];
    trir1_q <= prod_r[tpim_pkg::ProdW-1:1];
  end

  always_comb begin
    bad_pair = (req1_q.row_in >= req1_q.col_in) || (req1_q.col_in >= dim1_q);
    idx_calc = tpim_pkg::IdxW'(tot1_q - trir1_q + tpim_pkg::IdxW'(req1_q.col_in)
               - tpim_pkg::IdxW'(req1_q.row_in) - 31'd1);
    bad_idx  = req1_q.index_in >= tot1_q;
    q_back   = tot1_q - 31'd1 - req1_q.index_in;

    ctx2_d.op    = req1_q.op;
    ctx2_d.dim   = dim1_q;
    ctx2_d.total = tot1_q;
    if (req1_q.op == tpim_pkg::OpPairToIndex) begin
      ctx2_d.bad   = bad_pair;
      ctx2_d.row   = req1_q.row_in;
      ctx2_d.col   = req1_q.col_in;
      ctx2_d.index = bad_pair ? '0 : idx_calc;
    end else begin
      ctx2_d.bad   = bad_idx;
      ctx2_d.row   = '0;
      ctx2_d.col   = '0;
      ctx2_d.index = req1_q.index_in;
    end
    rad2_d = {q_back, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx2_q <= ctx2_d;
    rad2_q <= rad2_d;
  end

  assign valid_o = vld2_q;
  assign ctx_o   = ctx2_q;
  assign rad_o   = rad2_q;

endmodule

>>> sv/tpim_isqrt.sv
// Pipelined digit-by-digit integer square root, a few radicand digit pairs per
// stage, with the word context carried alongside. Depends on tpim_pkg.
module tpim_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tpim_pkg::tpim_ctx_t           ctx_i,
  input  logic [tpim_pkg::RadW-1:0]     rad_i,
  output logic                          valid_o,
  output tpim_pkg::tpim_ctx_t           ctx_o,
  output logic [tpim_pkg::RootW-1:0]    root_o
);

  localparam int unsigned NStg = tpim_pkg::SqrtStages;

  logic                          vld_q  [NStg];
  tpim_pkg::tpim_ctx_t           ctx_q  [NStg];
  logic [tpim_pkg::RemW-1:0]     rem_q  [NStg];
  logic [tpim_pkg::RootW-1:0]    root_q [NStg];
  logic [tpim_pkg::RadW-1:0]     rad_q  [NStg];

  logic                          vld_w  [NStg];
  tpim_pkg::tpim_ctx_t           ctx_w  [NStg];
  logic [tpim_pkg::RemW-1:0]     rem_w  [NStg];
  logic [tpim_pkg::RootW-1:0]    root_w [NStg];
  logic [tpim_pkg::RadW-1:0]     rad_w  [NStg];

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    logic [tpim_pkg::RemW-1:0]  rem_d;
    logic [tpim_pkg::RootW-1:0] root_d;
    logic [tpim_pkg::RadW-1:0]  rad_d;
    logic [tpim_pkg::RemW-1:0]  trial;

    if (g == 0) begin : g_src_in
      assign vld_w[g]  = valid_i;
      assign ctx_w[g]  = ctx_i;
      assign rem_w[g]  = '0;
      assign root_w[g] = '0;
      assign rad_w[g]  = rad_i;
    end else begin : g_src_prev
      assign vld_w[g]  = vld_q[g-1];
      assign ctx_w[g]  = ctx_q[g-1];
      assign rem_w[g]  = rem_q[g-1];
      assign root_w[g] = root_q[g-1];
      assign rad_w[g]  = rad_q[g-1];
    end

    always_comb begin
      rem_d  = rem_w[g];
      root_d = root_w[g];
      rad_d  = rad_w[g];
      trial  = '0;
      for (int i = 0; i < tpim_pkg::StepsPerStage; i++) begin
        rem_d = {rem_d[tpim_pkg::RemW-3:0], rad_d[tpim_pkg::RadW-1 -: 2]};
        rad_d = {rad_d[tpim_pkg::RadW-3:0], 2'b00};
        trial = {2'b00, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[tpim_pkg::RootW-2:0], 1'b1};
        end else begin
          root_d = {root_d[tpim_pkg::RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else begin
        vld_q[g] <= vld_w[g];
      end
    end

    always_ff @(posedge clk_i) begin
      ctx_q[g]  <= ctx_w[g];
      rem_q[g]  <= rem_d;
      root_q[g] <= root_d;
      rad_q[g]  <= rad_d;
    end
  end

  assign valid_o = vld_q[NStg-1];
  assign ctx_o   = ctx_q[NStg-1];
  assign root_o  = root_q[NStg-1];

endmodule

>>> sv/tpim_back.sv
// Back stages: root correction, row and column recovery, result word register.
// Depends on tpim_pkg.
module tpim_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  tpim_pkg::tpim_ctx_t           ctx_i,
  input  logic [tpim_pkg::RootW-1:0]    root_i,
  output logic                          valid_o,
  output tpim_pkg::tpim_res_t           res_o
);

  localparam int unsigned SqW = tpim_pkg::ProdW + 1;

  logic                          vld1_q;
  tpim_pkg::tpim_ctx_t           ctx1_q;
  logic [tpim_pkg::RootW-1:0]    s1_q;
  logic [SqW-1:0]                sq1_q;
  logic [SqW-1:0]                sq1_d;
  logic [tpim_pkg::RadW-1:0]     twoq1_q;
  logic [tpim_pkg::RadW-1:0]     twoq1_d;

  logic                          vld2_q;
  tpim_pkg::tpim_ctx_t           ctx2_q;
  logic [tpim_pkg::RowW-1:0]     m2;
  logic [tpim_pkg::ProdW-1:0]    trim_prod;
  logic [tpim_pkg::RowW-1:0]     row2_q;
  logic [tpim_pkg::IdxW-1:0]     tri2_q;

  logic                          vld3_q;
  tpim_pkg::tpim_res_t           res3_d;
  tpim_pkg::tpim_res_t           res3_q;
  logic [tpim_pkg::ProdW-1:0]    col_sum;

  always_comb begin
    sq1_d   = (SqW'(root_i) + 33'd1) * SqW'(root_i);
    twoq1_d = {tpim_pkg::IdxW'(ctx_i.total - 31'd1 - ctx_i.index), 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctx1_q  <= ctx_i;
    s1_q    <= root_i;
    sq1_q   <= sq1_d;
    twoq1_q <= twoq1_d;
  end

  always_comb begin
    m2        = (sq1_q <= SqW'(twoq1_q)) ? s1_q + 16'd1 : s1_q;
    trim_prod = tpim_pkg::ProdW'(m2 + 16'd1) * tpim_pkg::ProdW'(m2);
  end

  always_ff @(posedge clk_i) begin
    ctx2_q <= ctx1_q;
    row2_q <= ctx1_q.dim - 16'd1 - m2;
    tri2_q <= trim_prod[tpim_pkg::ProdW-1:1];
  end

  always_comb begin
    col_sum = tpim_pkg::ProdW'(row2_q) + 32'd1 + tpim_pkg::ProdW'(ctx2_q.index)
              + tpim_pkg::ProdW'(tri2_q) - tpim_pkg::ProdW'(ctx2_q.total);
    res3_d.index_out   = ctx2_q.index;
    res3_d.bad_operand = ctx2_q.bad;
    if (ctx2_q.op == tpim_pkg::OpIndexToPair && !ctx2_q.bad) begin
      res3_d.row_out = row2_q;
      res3_d.col_out = col_sum[tpim_pkg::RowW-1:0];
    end else begin
      res3_d.row_out = ctx2_q.row;
      res3_d.col_out = ctx2_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    res3_q <= res3_d;
  end

  assign valid_o = vld3_q;
  assign res_o   = res3_q;

endmodule

>>> dv/tb_triangular_pair_index_map_top.sv
// Self-checking testbench for triangular_pair_index_map_top: directed and random
// pair/index words across several matrix dimensions, checked against a local predictor.
// Depends on tpim_pkg and triangular_pair_index_map_top.
module tb_triangular_pair_index_map_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ActWord,
    ActDim,
    ActDrain
  } act_e;

  typedef struct {
    act_e                      kind;
    tpim_pkg::tpim_req_t       word;
    logic [tpim_pkg::RowW-1:0] dim;
    int unsigned               gap_odds;
  } plan_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  tpim_pkg::tpim_req_t       req_i = '0;
  logic                      done_o;
  tpim_pkg::tpim_res_t       res_o;
  logic                      cfg_we_i = 1'b0;
  logic [tpim_pkg::RowW-1:0] cfg_wdata_i = '0;

  plan_t                     plan_q[$];
  tpim_pkg::tpim_res_t       due_results[$];
  logic [tpim_pkg::RowW-1:0] dim_model = 16'd2;
  logic                      took_word = 1'b0;
  int unsigned               gap_left = 0;
  int unsigned               gap_odds = 0;
  int unsigned               mismatches = 0;

  triangular_pair_index_map_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [63:0] pair_count(logic [63:0] m);
    return (m == 0) ? 64'd0 : (m * (m - 1)) / 2;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    lo = 0;
    hi = 64'd1 << 18;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic tpim_pkg::tpim_res_t map_word(tpim_pkg::tpim_req_t w,
                                                   logic [tpim_pkg::RowW-1:0] dim);
    tpim_pkg::tpim_res_t res;
    logic [63:0]         n;
    logic [63:0]         total;
    logic [63:0]         r;
    logic [63:0]         c;
    logic [63:0]         k;
    logic [63:0]         root;
    n = 64'(dim);
    total = pair_count(n);
    res = '0;
    if (w.op == tpim_pkg::OpPairToIndex) begin
      r = 64'(w.row_in);
      c = 64'(w.col_in);
      res.row_out = w.row_in;
      res.col_out = w.col_in;
      res.bad_operand = (r >= c) || (c >= n);
      if (!res.bad_operand) begin
        res.index_out = tpim_pkg::IdxW'(total - pair_count(n - r) + c - r - 1);
      end
    end else begin
      k = 64'(w.index_in);
      res.index_out = w.index_in;
      if (k >= total) begin
        res.bad_operand = 1'b1;
      end else begin
        root = floor_root(4 * n * (n - 1) - 8 * k - 7);
        r = n - 2 - (root - 1) / 2;
        c = r + 1 + k - (total - pair_count(n - r));
        res.row_out = tpim_pkg::RowW'(r);
        res.col_out = tpim_pkg::RowW'(c);
      end
    end
    return res;
  endfunction

  function automatic tpim_pkg::tpim_req_t make_word(logic [tpim_pkg::RowW-1:0] n);
    tpim_pkg::tpim_req_t w;
    logic [63:0]         total;
    int unsigned         pick;
    w.op = 1'($urandom);
    w.row_in = tpim_pkg::RowW'($urandom);
    w.col_in = tpim_pkg::RowW'($urandom);
    w.index_in = tpim_pkg::IdxW'($urandom);
    total = pair_count(64'(n));
    pick = $urandom_range(0, 9);
    if (w.op == tpim_pkg::OpPairToIndex) begin
      if (n >= 2 && pick < 7) begin
        w.row_in = tpim_pkg::RowW'($urandom_range(0, 32'(n) - 2));
        w.col_in = tpim_pkg::RowW'($urandom_range(32'(w.row_in) + 1, 32'(n) - 1));
      end else if (pick == 7) begin
        w.col_in = n;
      end else if (pick == 8) begin
        w.col_in = w.row_in;
      end
    end else begin
      if (total != 0 && pick < 7) begin
        w.index_in = tpim_pkg::IdxW'($urandom_range(0, 32'(total - 1)));
      end else if (total != 0 && pick == 7) begin
        w.index_in = tpim_pkg::IdxW'(total - 1);
      end else if (pick == 8) begin
        w.index_in = tpim_pkg::IdxW'(total);
      end
    end
    return w;
  endfunction

  task automatic plan_word(tpim_pkg::tpim_req_t w, int unsigned odds);
    plan_t p;
    p.kind = ActWord;
    p.word = w;
    p.dim = '0;
    p.gap_odds = odds;
    plan_q.push_back(p);
  endtask

  task automatic plan_pair(logic [tpim_pkg::RowW-1:0] r, logic [tpim_pkg::RowW-1:0] c);
    tpim_pkg::tpim_req_t w;
    w.op = tpim_pkg::OpPairToIndex;
    w.row_in = r;
    w.col_in = c;
    w.index_in = tpim_pkg::IdxW'($urandom);
    plan_word(w, 4);
  endtask

  task automatic plan_index(logic [tpim_pkg::IdxW-1:0] k);
    tpim_pkg::tpim_req_t w;
    w.op = tpim_pkg::OpIndexToPair;
    w.row_in = tpim_pkg::RowW'($urandom);
    w.col_in = tpim_pkg::RowW'($urandom);
    w.index_in = k;
    plan_word(w, 4);
  endtask

  task automatic plan_control(act_e kind, logic [tpim_pkg::RowW-1:0] dim);
    plan_t p;
    p.kind = kind;
    p.word = '0;
    p.dim = dim;
    p.gap_odds = 0;
    plan_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Sample handshakes and results at the rising edge.
  always @(posedge clk_i) begin : monitor
    tpim_pkg::tpim_res_t want;
    if (rst_ni) begin
      took_word <= start && !busy;
      if (start && !busy) due_results.push_back(map_word(req_i, dim_model));
      if (cfg_we_i) dim_model = cfg_wdata_i;
      if (done_o) begin
        if (due_results.size() == 0) begin
          $error("result word with none pending: row %0d col %0d index %0d bad %0b",
                 res_o.row_out, res_o.col_out, res_o.index_out, res_o.bad_operand);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("row_out", 64'(want.row_out), 64'(res_o.row_out));
          check_field("col_out", 64'(want.col_out), 64'(res_o.col_out));
          check_field("index_out", 64'(want.index_out), 64'(res_o.index_out));
          check_field("bad_operand", 64'(want.bad_operand), 64'(res_o.bad_operand));
        end
      end
    end
  end

  // Drive words and register writes at the falling edge.
  always @(negedge clk_i) begin : driver
    logic nxt_start;
    logic nxt_we;
    if (rst_ni) begin
      nxt_start = start && !took_word;
      nxt_we = 1'b0;
      if (!nxt_start) begin
        if (gap_left == 0 && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          gap_left = $urandom_range(1, 13);
        if (gap_left != 0) begin
          gap_left--;
        end else if (plan_q.size() != 0) begin
          case (plan_q[0].kind)
            ActWord: begin
              req_i <= plan_q[0].word;
              gap_odds = plan_q[0].gap_odds;
              nxt_start = 1'b1;
              void'(plan_q.pop_front());
            end
            ActDim: begin
              if (due_results.size() == 0 && !start && !cfg_we_i) begin
                cfg_wdata_i <= plan_q[0].dim;
                nxt_we = 1'b1;
                void'(plan_q.pop_front());
              end
            end
            default: begin
              if (due_results.size() == 0) void'(plan_q.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  initial begin : stimulus
    logic [tpim_pkg::RowW-1:0] dims[$];
    int unsigned               odds[$];
    int unsigned               counts[$];
    // Directed: reset dimension of two.
    plan_pair(16'd0, 16'd1);
    plan_pair(16'd1, 16'd0);
    plan_pair(16'd0, 16'd0);
    plan_pair(16'hFFFF, 16'hFFFF);
    plan_index(31'd0);
    plan_index(31'd1);
    plan_index(31'h7FFF_FFFF);
    // Directed: largest dimension.
    plan_control(ActDim, 16'd65535);
    plan_pair(16'd0, 16'd1);
    plan_pair(16'd0, 16'd65534);
    plan_pair(16'd65533, 16'd65534);
    plan_pair(16'd65534, 16'd65534);
    plan_pair(16'd0, 16'd65535);
    plan_index(31'd0);
    plan_index(31'd2147385344);
    plan_index(31'd2147385345);
    plan_index(31'h7FFF_FFFF);
    // Directed: empty triangles.
    plan_control(ActDim, 16'd0);
    plan_pair(16'd0, 16'd1);
    plan_pair(16'd0, 16'd0);
    plan_index(31'd0);
    plan_control(ActDim, 16'd1);
    plan_pair(16'd0, 16'd1);
    plan_pair(16'd0, 16'd0);
    plan_index(31'd0);

    dims = '{16'd3, 16'd2, 16'd100, 16'd65535, 16'd7,
             tpim_pkg::RowW'($urandom_range(2, 65535)),
             16'd1000, 16'd0, 16'd40000, 16'd1, 16'd65535};
    odds = '{3, 12, 0, 4, 30, 6, 0, 3, 8, 5, 0};
    counts = '{160, 120, 160, 180, 150, 160, 160, 40, 180, 40, 200};
    foreach (dims[i]) begin
      plan_control(ActDim, dims[i]);
      for (int unsigned j = 0; j < counts[i]; j++) begin
        if (i == 3 && j == counts[i] / 2) plan_control(ActDrain, '0);
        plan_word(make_word(dims[i]), odds[i]);
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (plan_q.size() != 0 || start || due_results.size() != 0) @(posedge clk_i);
    repeat (tpim_pkg::Latency + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS triangular_pair_index_map_top");
    end else begin
      $display("FAIL triangular_pair_index_map_top");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAIL triangular_pair_index_map_top");
    $finish;
  end

endmodule
